FILE: sv/hsvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_pkg
// Shared types and constants of the HSV to ARGB converter pipeline.
// ----------------------------------------------------------------------------
package hsvc_pkg;

  localparam int unsigned HueW       = 15;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned FracW      = 12;
  localparam int unsigned SectorSpan = 3840;
  localparam int unsigned FullScale  = 255;
  localparam int unsigned ScaleDen   = SectorSpan * FullScale;   // 979200
  localparam int unsigned ProdW      = 20;                       // frac * sat
  localparam int unsigned WideW      = 28;                       // val * (D - frac*sat)
  localparam int unsigned CoarseW    = WideW - 8;                // product >> 8
  // ceil(2^32 / 3825), exact floor division for inputs below 2^20
  localparam int unsigned Recip      = 1122868;
  localparam int unsigned RecipW     = 21;
  localparam int unsigned RecipShift = 32;

  typedef enum logic [2:0] {
    SECTOR_RED_YELLOW    = 3'd0,
    SECTOR_YELLOW_GREEN  = 3'd1,
    SECTOR_GREEN_CYAN    = 3'd2,
    SECTOR_CYAN_BLUE     = 3'd3,
    SECTOR_BLUE_MAGENTA  = 3'd4,
    SECTOR_MAGENTA_RED   = 3'd5
  } sector_t;

  typedef struct packed {
    logic                 valid;
    sector_t              sector;
    logic [FracW-1:0]     frac;
    logic [ByteW-1:0]     sat;
    logic [ByteW-1:0]     val;
    logic [ByteW-1:0]     alp;
  } split_t;

  typedef struct packed {
    logic                 valid;
    sector_t              sector;
    logic [ByteW-1:0]     val;
    logic [ByteW-1:0]     alp;
    logic [ByteW-1:0]     pv;
    logic [ByteW-1:0]     qv;
    logic [ByteW-1:0]     tv;
  } scaled_t;

endpackage

FILE: sv/hsvc_sector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_sector
// First pipeline stage: splits hue into sector (mod 6) and in-sector fraction.
// ----------------------------------------------------------------------------
module hsvc_sector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [hsvc_pkg::HueW-1:0]     hue,
  input  logic [hsvc_pkg::ByteW-1:0]    saturation,
  input  logic [hsvc_pkg::ByteW-1:0]    brightness,
  input  logic [hsvc_pkg::ByteW-1:0]    opacity,
  output hsvc_pkg::split_t              split
);

  logic [6:0]                      hue_coarse;
  logic [3:0]                      raw;
  logic [3:0]                      raw_mod;
  logic [hsvc_pkg::HueW-1:0]       base;
  logic [hsvc_pkg::HueW-1:0]       frac_full;

  // hue / 3840 == (hue >> 8) / 15
  assign hue_coarse = hue[hsvc_pkg::HueW-1:8];

  always_comb begin
    raw = '0;
    for (int k = 1; k <= 8; k++) begin
      if (hue_coarse >= 7'(k * 15)) begin
        raw = raw + 4'd1;
      end
    end
  end

  assign raw_mod   = (raw >= 4'd6) ? raw - 4'd6 : raw;
  assign base      = hsvc_pkg::HueW'(raw) * hsvc_pkg::HueW'(hsvc_pkg::SectorSpan);
  assign frac_full = hue - base;

  always_ff @(posedge clk) begin
    if (rst) begin
      split.valid <= 1'b0;
    end else begin
      split.valid <= in_valid;
    end
    split.sector <= hsvc_pkg::sector_t'(raw_mod[2:0]);
    split.frac   <= frac_full[hsvc_pkg::FracW-1:0];
    split.sat    <= saturation;
    split.val    <= brightness;
    split.alp    <= opacity;
  end

endmodule

FILE: sv/hsvc_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvc_scale
// Three pipeline stages computing the p, q and t channel bytes.
// ----------------------------------------------------------------------------
module hsvc_scale (
  input  logic               clk,
  input  logic               rst,
  input  hsvc_pkg::split_t   split,
  output hsvc_pkg::scaled_t  scaled
);

  localparam int unsigned PW = hsvc_pkg::ProdW;
  localparam int unsigned WW = hsvc_pkg::WideW;
  localparam int unsigned CW = hsvc_pkg::CoarseW;
  localparam int unsigned BW = hsvc_pkg::ByteW;
  localparam int unsigned MW = CW + hsvc_pkg::RecipW;

  // stage A: fraction products
  logic                  a_valid;
  hsvc_pkg::sector_t     a_sector;
  logic [BW-1:0]         a_val;
  logic [BW-1:0]         a_alp;
  logic [PW-1:0]         a_fs;
  logic [PW-1:0]         a_gs;
  logic [2*BW-1:0]       a_pnum;

  // stage B: wide products and p
  logic                  b_valid;
  hsvc_pkg::sector_t     b_sector;
  logic [BW-1:0]         b_val;
  logic [BW-1:0]         b_alp;
  logic [BW-1:0]         b_pv;
  logic [WW-1:0]         b_qprod;
  logic [WW-1:0]         b_tprod;

  logic [hsvc_pkg::FracW-1:0] frac_rest;
  logic [PW-1:0]         qn;
  logic [PW-1:0]         tn;
  logic [2*BW:0]         p_sum;
  logic [MW-1:0]         q_mul;
  logic [MW-1:0]         t_mul;

  assign frac_rest = hsvc_pkg::FracW'(hsvc_pkg::SectorSpan) - split.frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= split.valid;
    end
    a_sector <= split.sector;
    a_val    <= split.val;
    a_alp    <= split.alp;
    a_fs     <= PW'(split.frac) * PW'(split.sat);
    a_gs     <= PW'(frac_rest) * PW'(split.sat);
    a_pnum   <= (2*BW)'(split.val) * (2*BW)'(BW'(hsvc_pkg::FullScale) - split.sat);
  end

  assign qn    = PW'(hsvc_pkg::ScaleDen) - a_fs;
  assign tn    = PW'(hsvc_pkg::ScaleDen) - a_gs;
  // x / 255 for x <= 255*255
  assign p_sum = (2*BW+1)'(a_pnum) + (2*BW+1)'(a_pnum >> 8) + (2*BW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_sector <= a_sector;
    b_val    <= a_val;
    b_alp    <= a_alp;
    b_pv     <= p_sum[2*BW-1:BW];
    b_qprod  <= WW'(a_val) * WW'(qn);
    b_tprod  <= WW'(a_val) * WW'(tn);
  end

  // x / 979200 == (x >> 8) / 3825, by reciprocal
  assign q_mul = MW'(b_qprod[WW-1:8]) * MW'(hsvc_pkg::Recip);
  assign t_mul = MW'(b_tprod[WW-1:8]) * MW'(hsvc_pkg::Recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled.valid <= 1'b0;
    end else begin
      scaled.valid <= b_valid;
    end
    scaled.sector <= b_sector;
    scaled.val    <= b_val;
    scaled.alp    <= b_alp;
    scaled.pv     <= b_pv;
    scaled.qv     <= q_mul[hsvc_pkg::RecipShift+BW-1:hsvc_pkg::RecipShift];
    scaled.tv     <= t_mul[hsvc_pkg::RecipShift+BW-1:hsvc_pkg::RecipShift];
  end

endmodule

FILE: sv/hsv_to_argb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_argb_converter
// Six-sector HSV to 8-bit ARGB conversion, fully pipelined.
// ----------------------------------------------------------------------------
// One color word is taken in every clock cycle: busy is always low, so a
// word is accepted whenever start is high. Each word passes through five
// register stages: sector split, fraction products, value products,
// reciprocal scaling and channel select. Its result then appears on the
// result ports, marked by done for one cycle, and must be taken then; the
// receiver cannot stall the pipeline.
module hsv_to_argb_converter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [hsvc_pkg::HueW-1:0]     hue,
  input  logic [hsvc_pkg::ByteW-1:0]    saturation,
  input  logic [hsvc_pkg::ByteW-1:0]    brightness,
  input  logic [hsvc_pkg::ByteW-1:0]    opacity,
  output logic                          done,
  output logic [hsvc_pkg::ByteW-1:0]    red,
  output logic [hsvc_pkg::ByteW-1:0]    green,
  output logic [hsvc_pkg::ByteW-1:0]    blue,
  output logic [hsvc_pkg::ByteW-1:0]    alpha_out,
  output logic [4*hsvc_pkg::ByteW-1:0]  packed_argb
);

  hsvc_pkg::split_t   split;
  hsvc_pkg::scaled_t  scaled;
  logic [hsvc_pkg::ByteW-1:0] r_next;
  logic [hsvc_pkg::ByteW-1:0] g_next;
  logic [hsvc_pkg::ByteW-1:0] b_next;

  assign busy = 1'b0;

  hsvc_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .opacity    (opacity),
    .split      (split)
  );

  hsvc_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .split  (split),
    .scaled (scaled)
  );

  always_comb begin
    unique case (scaled.sector)
      hsvc_pkg::SECTOR_RED_YELLOW: begin
        r_next = scaled.val; g_next = scaled.tv;  b_next = scaled.pv;
      end
      hsvc_pkg::SECTOR_YELLOW_GREEN: begin
        r_next = scaled.qv;  g_next = scaled.val; b_next = scaled.pv;
      end
      hsvc_pkg::SECTOR_GREEN_CYAN: begin
        r_next = scaled.pv;  g_next = scaled.val; b_next = scaled.tv;
      end
      hsvc_pkg::SECTOR_CYAN_BLUE: begin
        r_next = scaled.pv;  g_next = scaled.qv;  b_next = scaled.val;
      end
      hsvc_pkg::SECTOR_BLUE_MAGENTA: begin
        r_next = scaled.tv;  g_next = scaled.pv;  b_next = scaled.val;
      end
      default: begin
        r_next = scaled.val; g_next = scaled.pv;  b_next = scaled.qv;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= scaled.valid;
    end
    red         <= r_next;
    green       <= g_next;
    blue        <= b_next;
    alpha_out   <= scaled.alp;
    packed_argb <= {scaled.alp, r_next, g_next, b_next};
  end

  // every result traces back to an input word taken on start
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5))
    else $error("result without a matching input word");

  a_packed: assert property (@(posedge clk) disable iff (rst)
    done |-> packed_argb == {alpha_out, red, green, blue})
    else $error("packed word disagrees with channel bytes");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    done |-> alpha_out == $past(opacity, 5))
    else $error("alpha lost alignment with its word");

  // zero saturation gives a gray
  a_gray: assert property (@(posedge clk) disable iff (rst)
    (done && $past(saturation, 5) == 8'd0) |-> (red == green && green == blue))
    else $error("gray input produced a tinted result");

endmodule
